/* rtl/core/radix_digit_converter_macros.svh */
// ----------------------------------------------------------------------------
// radix_digit_converter_macros
// Assertion macros shared by the converter; empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef RADIX_DIGIT_CONVERTER_MACROS_SVH
`define RADIX_DIGIT_CONVERTER_MACROS_SVH

`ifndef SYNTHESIS
`define RDC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("radix_digit_converter: assertion failed");
`define RDC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("radix_digit_converter: assertion failed");
`else
`define RDC_ASSERT_IMP(label, ante, cons)
`define RDC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* rtl/core/rdc_pkg.sv */
// ----------------------------------------------------------------------------
// rdc_pkg
// Widths, constants, state encoding and helpers for the radix converter.
// ----------------------------------------------------------------------------
package rdc_pkg;

  localparam int VALUE_W     = 32;
  localparam int RADIX_IN_W  = 8;
  localparam int CHAR_W      = 7;
  localparam int DIGIT_W     = 4;

  localparam int VALUE_BITS  = 31;
  localparam int STORE_DEPTH = 32;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int COUNT_W     = ADDR_W + 1;

  localparam int RADIX_MIN   = 2;
  localparam int RADIX_MAX   = 16;
  localparam int RADIX_W     = $clog2(RADIX_MAX + 1);
  localparam int REM_W       = RADIX_W + 1;

  localparam int RECIP_SHIFT = VALUE_BITS + 1;
  localparam int RECIP_W     = VALUE_BITS + 1;
  localparam int PROD_W      = VALUE_BITS + RECIP_W;
  localparam logic [63:0] RECIP_ONE = 64'd1 << RECIP_SHIFT;

  localparam logic [DIGIT_W-1:0] DECIMAL_LIMIT = 4'd10;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO     = 7'h30;
  localparam logic [CHAR_W-1:0]  CHAR_UPPER_A  = 7'h41;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_FIX,
    ST_FETCH,
    ST_SEND,
    ST_ERR
  } state_t;

  // floor(2^RECIP_SHIFT / r), the quotient estimate is low by at most one
  function automatic logic [RECIP_W-1:0] recip(input logic [RADIX_W-1:0] r);
    logic [RECIP_W-1:0] m;
    case (r)
      5'd2:    m = RECIP_W'(RECIP_ONE / 2);
      5'd3:    m = RECIP_W'(RECIP_ONE / 3);
      5'd4:    m = RECIP_W'(RECIP_ONE / 4);
      5'd5:    m = RECIP_W'(RECIP_ONE / 5);
      5'd6:    m = RECIP_W'(RECIP_ONE / 6);
      5'd7:    m = RECIP_W'(RECIP_ONE / 7);
      5'd8:    m = RECIP_W'(RECIP_ONE / 8);
      5'd9:    m = RECIP_W'(RECIP_ONE / 9);
      5'd10:   m = RECIP_W'(RECIP_ONE / 10);
      5'd11:   m = RECIP_W'(RECIP_ONE / 11);
      5'd12:   m = RECIP_W'(RECIP_ONE / 12);
      5'd13:   m = RECIP_W'(RECIP_ONE / 13);
      5'd14:   m = RECIP_W'(RECIP_ONE / 14);
      5'd15:   m = RECIP_W'(RECIP_ONE / 15);
      5'd16:   m = RECIP_W'(RECIP_ONE / 16);
      default: m = '0;
    endcase
    return m;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d >= DECIMAL_LIMIT) begin
      c = CHAR_UPPER_A + CHAR_W'(d - DECIMAL_LIMIT);
    end else begin
      c = CHAR_ZERO + CHAR_W'(d);
    end
    return c;
  endfunction

endpackage

/* rtl/core/rdc_channels.sv */
// ----------------------------------------------------------------------------
// rdc_channels
// Request and result channel interfaces with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rdc_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [rdc_pkg::VALUE_W-1:0]   value;
  logic        [rdc_pkg::RADIX_IN_W-1:0] radix;

  modport source (output valid, output value, output radix, input ready);
  modport sink   (input valid, input value, input radix, output ready);
endinterface

interface rdc_out_if;
  logic                          valid;
  logic                          ready;
  logic [rdc_pkg::CHAR_W-1:0]    digit_char;
  logic                          error;
  logic                          last;

  modport source (output valid, output digit_char, output error, output last, input ready);
  modport sink   (input valid, input digit_char, input error, input last, output ready);
endinterface

/* rtl/core/rdc_ram.sv */
// ----------------------------------------------------------------------------
// rdc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rdc_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/rdc_div_unit.sv */
// ----------------------------------------------------------------------------
// rdc_div_unit
// Shared divide-by-radix step: reciprocal multiply, then one-step correction.
// ----------------------------------------------------------------------------
module rdc_div_unit (
  input  logic                            clk,
  input  logic                            start,
  input  logic [rdc_pkg::VALUE_BITS-1:0]  dividend,
  input  logic [rdc_pkg::RADIX_W-1:0]     divisor,
  output logic [rdc_pkg::VALUE_BITS-1:0]  quotient,
  output logic [rdc_pkg::DIGIT_W-1:0]     remainder
);
  import rdc_pkg::*;

  logic [PROD_W-1:0]     prod_in;
  logic [PROD_W-1:0]     prod;
  logic [VALUE_BITS-1:0] num;
  logic [RADIX_W-1:0]    den;
  logic [VALUE_BITS-1:0] est;
  logic [REM_W-1:0]      back_lo;
  logic [REM_W-1:0]      diff;
  logic                  fix;

  assign prod_in = PROD_W'(dividend) * PROD_W'(recip(divisor));

  always_ff @(posedge clk) begin
    if (start) begin
      prod <= prod_in;
      num  <= dividend;
      den  <= divisor;
    end
  end

  // remainder is below twice the radix, so only the low bits matter
  assign est      = prod[RECIP_SHIFT +: VALUE_BITS];
  assign back_lo  = REM_W'(est[REM_W-1:0] * REM_W'(den));
  assign diff     = num[REM_W-1:0] - back_lo;
  assign fix      = diff >= REM_W'(den);
  assign quotient = fix ? est + VALUE_BITS'(1) : est;
  assign remainder = fix ? DIGIT_W'(diff - REM_W'(den)) : DIGIT_W'(diff);

endmodule

/* rtl/core/radix_digit_converter.sv */
// ----------------------------------------------------------------------------
// radix_digit_converter
// Integer to ASCII digit string in a radix from 2 to 16.
// ----------------------------------------------------------------------------
// din carries one request: a signed 32-bit value and an 8-bit radix.
// dout returns the digits as ASCII characters, most significant first,
// '0'-'9' then 'A'-'F', with last set on the final character. A zero value
// gives the single character '0'. A radix outside 2..16 or a negative value
// gives one result with error and last set and digit_char zero.
// Each digit passes through the shared divide unit as a reciprocal
// multiply, then correction and store write; each character is a digit
// store read, then a send. din.ready is high only between requests.
// When the receiver stalls, the pending character holds on dout until
// taken. Reset returns the sequencer to idle; the digit store needs no
// clearing since only digits of the current request are read.
// ----------------------------------------------------------------------------
`include "radix_digit_converter_macros.svh"

module radix_digit_converter (
  input  logic      clk,
  input  logic      rst,
  rdc_in_if.sink    din,
  rdc_out_if.source dout
);
  import rdc_pkg::*;

  state_t                state;
  state_t                state_next;
  logic [VALUE_BITS-1:0] quot;
  logic [RADIX_W-1:0]    radix_r;
  logic [COUNT_W-1:0]    digit_count;
  logic [ADDR_W-1:0]     rptr;

  logic                  in_bad;
  logic                  div_start;
  logic [VALUE_BITS-1:0] div_quot;
  logic [DIGIT_W-1:0]    div_rem;
  logic                  ram_we;
  logic [DIGIT_W-1:0]    ram_rdata;

  assign in_bad = (din.radix < RADIX_MIN) || (din.radix > RADIX_MAX) ||
                  (din.value[VALUE_W-1:VALUE_BITS] != '0);

  rdc_div_unit u_div (
    .clk       (clk),
    .start     (div_start),
    .dividend  (quot),
    .divisor   (radix_r),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  rdc_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (digit_count[ADDR_W-1:0]),
    .wdata (div_rem),
    .raddr (rptr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (din.valid) begin
          state_next = in_bad ? ST_ERR : ST_MUL;
        end
      end
      ST_MUL: begin
        state_next = ST_FIX;
      end
      ST_FIX: begin
        state_next = (div_quot == '0) ? ST_FETCH : ST_MUL;
      end
      ST_FETCH: begin
        state_next = ST_SEND;
      end
      ST_SEND: begin
        if (dout.ready) begin
          state_next = (rptr == '0) ? ST_IDLE : ST_FETCH;
        end
      end
      ST_ERR: begin
        if (dout.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    din.ready       = 1'b0;
    div_start       = 1'b0;
    ram_we          = 1'b0;
    dout.valid      = 1'b0;
    dout.error      = 1'b0;
    dout.last       = 1'b0;
    dout.digit_char = digit_to_ascii(ram_rdata);
    unique case (state)
      ST_IDLE:  din.ready = 1'b1;
      ST_MUL:   div_start = 1'b1;
      ST_FIX:   ram_we    = 1'b1;
      ST_FETCH: ;
      ST_SEND: begin
        dout.valid = 1'b1;
        dout.last  = (rptr == '0);
      end
      ST_ERR: begin
        dout.valid      = 1'b1;
        dout.error      = 1'b1;
        dout.last       = 1'b1;
        dout.digit_char = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      quot        <= '0;
      digit_count <= '0;
      rptr        <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (din.valid && !in_bad) begin
            quot        <= din.value[VALUE_BITS-1:0];
            radix_r     <= din.radix[RADIX_W-1:0];
            digit_count <= '0;
          end
        end
        ST_FIX: begin
          quot        <= div_quot;
          digit_count <= digit_count + COUNT_W'(1);
          if (div_quot == '0) begin
            rptr <= digit_count[ADDR_W-1:0];
          end
        end
        ST_SEND: begin
          if (dout.ready && (rptr != '0)) begin
            rptr <= rptr - ADDR_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  `RDC_ASSERT_IMP(a_no_overlap, din.ready, !dout.valid)
  `RDC_ASSERT_IMP(a_err_shape, dout.valid && dout.error, dout.last && (dout.digit_char == '0))
  `RDC_ASSERT_NEXT(a_err_resp, din.valid && din.ready && in_bad, dout.valid && dout.error)
  `RDC_ASSERT_NEXT(a_ok_resp, din.valid && din.ready && !in_bad, !dout.valid && !din.ready)

endmodule
